[rtl/swb_pkg.sv]
// swb_pkg: shared types and constants of the subtract-with-borrow generator
// used by the interfaces, the seed sequencer and the top level
package swb_pkg;

    localparam int WORD_W  = 32;
    localparam int MUL_B_W = 13;
    localparam int PROD_W  = 8;

    // request codes
    localparam logic REQ_SEED = 1'b0;
    localparam logic REQ_NEXT = 1'b1;

    // seed arithmetic constants
    localparam logic [WORD_W-1:0]  LCG_MUL    = 32'd8191;
    localparam logic [WORD_W-1:0]  LCG_ADD    = 32'd131071;
    localparam logic [WORD_W-1:0]  CONG_MUL   = 32'd53;
    localparam logic [WORD_W-1:0]  CONG_ADD   = 32'd1;
    localparam int                 PROD_MOD   = 179;
    localparam int                 CONG_MOD   = 169;
    localparam int                 BIT_MOD    = 63;
    localparam int                 BIT_THRESH = 32;

    // top level control
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_SEED
    } swb_state_t;

    // seed sequencer states
    typedef enum logic [3:0] {
        SD_IDLE,
        SD_INIT_MUL,
        SD_INIT_MOD,
        SD_P1_MUL,
        SD_P1_MOD,
        SD_P2_MUL,
        SD_P2_MOD,
        SD_C_MUL,
        SD_C_MOD,
        SD_B_MUL,
        SD_B_MOD
    } swb_seed_state_t;

    // status from the seed sequencer to the top level
    typedef struct packed {
        logic wr_en;
        logic done;
    } swb_seed_status_t;

endpackage

[rtl/swb_if.sv]
// swb_if: request and response channels of the generator
// depends on swb_pkg for the word width
interface swb_req_if;
    logic                       valid;
    logic                       ready;
    logic                       req_type;
    logic [swb_pkg::WORD_W-1:0] seed_value;

    modport source (output valid, output req_type, output seed_value, input ready);
    modport sink   (input valid, input req_type, input seed_value, output ready);
endinterface

interface swb_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [swb_pkg::WORD_W-1:0] random_word;

    modport source (output valid, output random_word, input ready);
    modport sink   (input valid, input random_word, output ready);
endinterface

[rtl/swb_ram.sv]
// swb_ram: generic single write, single read memory with registered read data
// no dependencies
module swb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 43
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/swb_seeder.sv]
// swb_seeder: multi-cycle sequencer that builds the ring words from a seed
// one shared multiplier and a byte-serial modulo unit; depends on swb_pkg
module swb_seeder #(
    parameter int LONG_LAG = 43
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [swb_pkg::WORD_W-1:0]          seed,
    output swb_pkg::swb_seed_status_t           status,
    output logic [$clog2(LONG_LAG)-1:0]         wr_addr,
    output logic [swb_pkg::WORD_W-1:0]          wr_data
);

    localparam int PTR_W = $clog2(LONG_LAG);
    localparam int HW    = (PTR_W > 8) ? PTR_W : 8;
    localparam int MOD_W = HW + 1;
    localparam int MUL_W = swb_pkg::WORD_W + swb_pkg::MUL_B_W;

    swb_pkg::swb_seed_state_t state_reg, state_next;

    logic [swb_pkg::WORD_W-1:0]  t_reg;
    logic [swb_pkg::WORD_W-1:0]  cong_reg;
    logic [HW-1:0]               hist0_reg, hist1_reg, hist2_reg;
    logic [swb_pkg::PROD_W-1:0]  prod_reg;
    logic [swb_pkg::WORD_W-1:0]  acc_reg;
    logic [MOD_W-1:0]            rem_reg;
    logic [1:0]                  digit_reg;
    logic [1:0]                  init_cnt_reg;
    logic [4:0]                  bit_cnt_reg;
    logic [PTR_W-1:0]            word_reg;

    logic [swb_pkg::WORD_W-1:0]  mul_a;
    logic [swb_pkg::MUL_B_W-1:0] mul_b;
    logic [swb_pkg::WORD_W-1:0]  mul_add;
    logic [MUL_W-1:0]            mul_full;
    logic [swb_pkg::WORD_W-1:0]  mul_res;
    logic [MOD_W-1:0]            modulus;
    logic [MOD_W-1:0]            rem_step;
    logic                        mod_last;
    logic                        rand_bit;
    logic                        last_bit;
    logic                        last_word;

    // multiplier operand selection
    always_comb
    begin
        mul_a   = t_reg;
        mul_b   = swb_pkg::MUL_B_W'(swb_pkg::LCG_MUL);
        mul_add = swb_pkg::LCG_ADD;
        case (state_reg)
            swb_pkg::SD_P1_MUL:
            begin
                mul_a   = swb_pkg::WORD_W'(hist0_reg);
                mul_b   = swb_pkg::MUL_B_W'(hist1_reg);
                mul_add = '0;
            end
            swb_pkg::SD_P2_MUL:
            begin
                mul_a   = t_reg;
                mul_b   = swb_pkg::MUL_B_W'(hist2_reg);
                mul_add = '0;
            end
            swb_pkg::SD_C_MUL:
            begin
                mul_a   = cong_reg;
                mul_b   = swb_pkg::MUL_B_W'(swb_pkg::CONG_MUL);
                mul_add = swb_pkg::CONG_ADD;
            end
            swb_pkg::SD_B_MUL:
            begin
                mul_a   = swb_pkg::WORD_W'(prod_reg);
                mul_b   = swb_pkg::MUL_B_W'(cong_reg[7:0]);
                mul_add = '0;
            end
            default:
            begin
                mul_a   = t_reg;
                mul_b   = swb_pkg::MUL_B_W'(swb_pkg::LCG_MUL);
                mul_add = swb_pkg::LCG_ADD;
            end
        endcase
    end

    // shared multiplier, product wraps at 32 bits
    assign mul_full = MUL_W'(mul_a) * MUL_W'(mul_b);
    assign mul_res  = mul_full[swb_pkg::WORD_W-1:0] + mul_add;

    // modulus for the running reduction
    always_comb
    begin
        case (state_reg)
            swb_pkg::SD_INIT_MOD: modulus = MOD_W'(LONG_LAG);
            swb_pkg::SD_P1_MOD,
            swb_pkg::SD_P2_MOD:   modulus = MOD_W'(swb_pkg::PROD_MOD);
            swb_pkg::SD_C_MOD:    modulus = MOD_W'(swb_pkg::CONG_MOD);
            default:              modulus = MOD_W'(swb_pkg::BIT_MOD);
        endcase
    end

    // restoring reduction over the top byte of t_reg
    always_comb
    begin
        logic [MOD_W-1:0] r;
        r = rem_reg;
        for (int i = 0; i < 8; i++)
        begin
            r = {r[MOD_W-2:0], t_reg[swb_pkg::WORD_W-1-i]};
            if (r >= modulus)
            begin
                r = r - modulus;
            end
        end
        rem_step = r;
    end

    assign mod_last  = (digit_reg == 2'd3);
    assign rand_bit  = (rem_step >= MOD_W'(swb_pkg::BIT_THRESH));
    assign last_bit  = (bit_cnt_reg == 5'd31);
    assign last_word = (word_reg == PTR_W'(LONG_LAG - 1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            swb_pkg::SD_IDLE:     if (start) state_next = swb_pkg::SD_INIT_MUL;
            swb_pkg::SD_INIT_MUL: state_next = swb_pkg::SD_INIT_MOD;
            swb_pkg::SD_INIT_MOD:
            begin
                if (mod_last)
                begin
                    state_next = (init_cnt_reg == 2'd2) ? swb_pkg::SD_P1_MUL :
                                                          swb_pkg::SD_INIT_MUL;
                end
            end
            swb_pkg::SD_P1_MUL:   state_next = swb_pkg::SD_P1_MOD;
            swb_pkg::SD_P1_MOD:   if (mod_last) state_next = swb_pkg::SD_P2_MUL;
            swb_pkg::SD_P2_MUL:   state_next = swb_pkg::SD_P2_MOD;
            swb_pkg::SD_P2_MOD:   if (mod_last) state_next = swb_pkg::SD_C_MUL;
            swb_pkg::SD_C_MUL:    state_next = swb_pkg::SD_C_MOD;
            swb_pkg::SD_C_MOD:    if (mod_last) state_next = swb_pkg::SD_B_MUL;
            swb_pkg::SD_B_MUL:    state_next = swb_pkg::SD_B_MOD;
            swb_pkg::SD_B_MOD:
            begin
                if (mod_last)
                begin
                    state_next = (last_bit && last_word) ? swb_pkg::SD_IDLE :
                                                           swb_pkg::SD_P1_MUL;
                end
            end
            default:              state_next = swb_pkg::SD_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        status.wr_en = (state_reg == swb_pkg::SD_B_MOD) && mod_last && last_bit;
        status.done  = status.wr_en && last_word;
        wr_addr      = word_reg;
        wr_data      = {acc_reg[swb_pkg::WORD_W-2:0], rand_bit};
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= swb_pkg::SD_IDLE;
            digit_reg    <= '0;
            init_cnt_reg <= '0;
            bit_cnt_reg  <= '0;
            word_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                swb_pkg::SD_IDLE:
                begin
                    init_cnt_reg <= '0;
                    bit_cnt_reg  <= '0;
                    word_reg     <= '0;
                end
                swb_pkg::SD_INIT_MUL, swb_pkg::SD_P1_MUL, swb_pkg::SD_P2_MUL,
                swb_pkg::SD_C_MUL, swb_pkg::SD_B_MUL:
                begin
                    digit_reg <= '0;
                end
                swb_pkg::SD_INIT_MOD:
                begin
                    digit_reg <= digit_reg + 2'd1;
                    if (mod_last)
                    begin
                        init_cnt_reg <= init_cnt_reg + 2'd1;
                    end
                end
                swb_pkg::SD_B_MOD:
                begin
                    digit_reg <= digit_reg + 2'd1;
                    if (mod_last)
                    begin
                        bit_cnt_reg <= bit_cnt_reg + 5'd1;
                        if (last_bit)
                        begin
                            word_reg <= word_reg + 1'b1;
                        end
                    end
                end
                default:
                begin
                    digit_reg <= digit_reg + 2'd1;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            swb_pkg::SD_IDLE:
            begin
                if (start)
                begin
                    t_reg    <= seed;
                    cong_reg <= seed;
                end
            end
            swb_pkg::SD_INIT_MUL, swb_pkg::SD_P1_MUL, swb_pkg::SD_P2_MUL,
            swb_pkg::SD_C_MUL, swb_pkg::SD_B_MUL:
            begin
                t_reg   <= mul_res;
                rem_reg <= '0;
            end
            default:
            begin
                rem_reg <= rem_step;
                if (!mod_last)
                begin
                    // next byte of the dividend
                    t_reg <= {t_reg[swb_pkg::WORD_W-9:0], 8'h00};
                end
                else
                begin
                    case (state_reg)
                        swb_pkg::SD_INIT_MOD:
                        begin
                            hist0_reg <= hist1_reg;
                            hist1_reg <= hist2_reg;
                            hist2_reg <= rem_step[HW-1:0];
                            t_reg     <= swb_pkg::WORD_W'(rem_step);
                        end
                        swb_pkg::SD_P1_MOD:
                        begin
                            t_reg <= swb_pkg::WORD_W'(rem_step);
                        end
                        swb_pkg::SD_P2_MOD:
                        begin
                            prod_reg <= rem_step[swb_pkg::PROD_W-1:0];
                        end
                        swb_pkg::SD_C_MOD:
                        begin
                            cong_reg <= swb_pkg::WORD_W'(rem_step);
                        end
                        default:
                        begin
                            // bit done: shift into word, retire oldest history value
                            acc_reg   <= {acc_reg[swb_pkg::WORD_W-2:0], rand_bit};
                            hist0_reg <= hist1_reg;
                            hist1_reg <= hist2_reg;
                            hist2_reg <= HW'(prod_reg);
                        end
                    endcase
                end
            end
        endcase
    end

endmodule

[rtl/swb_random_generator_unit.sv]
// swb_random_generator_unit: top level of the subtract-with-borrow generator
// depends on swb_pkg, swb_if, swb_ram and swb_seeder
//
// Subtract-with-borrow generator with lags LONG_LAG and SHORT_LAG on 32-bit
// words. The lag ring lives in two copies of a small synchronous RAM, one read
// at the current slot and one at the short-lag slot, both written together. A
// next request reads both lags at the accepting edge; in ST_CALC the generator
// subtracts with borrow, writes the slot back and loads the output register
// (it waits there only while an earlier word is still pending). A seed
// request is worked out by a sequencer with one shared multiplier and a
// byte-serial modulo unit; no request is taken while it runs. Ring slots
// never written since reset read as zero.
module swb_random_generator_unit #(
    parameter int LONG_LAG  = 43,
    parameter int SHORT_LAG = 22
) (
    input  logic     clk,
    input  logic     rst_n,
    swb_req_if.sink  req,
    swb_rsp_if.source rsp
);

    localparam int PTR_W = $clog2(LONG_LAG);
    localparam int SHIFT = LONG_LAG - (SHORT_LAG % LONG_LAG);

    swb_pkg::swb_state_t state_reg, state_next;

    logic [PTR_W-1:0]           ptr_reg, ptr_next;
    logic                       borrow_reg;
    logic [LONG_LAG-1:0]        slot_valid_reg;
    logic                       rd_long_valid_reg;
    logic                       rd_short_valid_reg;
    logic                       out_valid_reg;
    logic [swb_pkg::WORD_W-1:0] out_word_reg;

    logic [PTR_W:0]             q_sum;
    logic [PTR_W-1:0]           q_ptr;
    logic [swb_pkg::WORD_W-1:0] rd_long;
    logic [swb_pkg::WORD_W-1:0] rd_short;
    logic [swb_pkg::WORD_W-1:0] lag_long;
    logic [swb_pkg::WORD_W-1:0] lag_short;
    logic [swb_pkg::WORD_W:0]   sub_sum;
    logic [swb_pkg::WORD_W:0]   diff;
    logic                       borrow_next;

    logic                       req_fire;
    logic                       calc_en;
    logic                       calc_fire;
    logic                       seed_start;
    logic                       seeding;

    swb_pkg::swb_seed_status_t  seed_status;
    logic [PTR_W-1:0]           seed_addr;
    logic [swb_pkg::WORD_W-1:0] seed_data;

    logic                       wr_en;
    logic [PTR_W-1:0]           wr_addr;
    logic [swb_pkg::WORD_W-1:0] wr_data;

    // short-lag slot
    assign q_sum = {1'b0, ptr_reg} + (PTR_W+1)'(SHIFT);
    assign q_ptr = (q_sum >= (PTR_W+1)'(LONG_LAG)) ?
                   PTR_W'(q_sum - (PTR_W+1)'(LONG_LAG)) : q_sum[PTR_W-1:0];

    // ring copies: long lag at the pointer, short lag at q_ptr
    swb_ram #(
        .WIDTH (swb_pkg::WORD_W),
        .DEPTH (LONG_LAG)
    ) u_ram_long (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (ptr_reg),
        .rd_data (rd_long)
    );

    swb_ram #(
        .WIDTH (swb_pkg::WORD_W),
        .DEPTH (LONG_LAG)
    ) u_ram_short (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (q_ptr),
        .rd_data (rd_short)
    );

    // seed sequencer
    swb_seeder #(
        .LONG_LAG (LONG_LAG)
    ) u_seeder (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (seed_start),
        .seed    (req.seed_value),
        .status  (seed_status),
        .wr_addr (seed_addr),
        .wr_data (seed_data)
    );

    // subtract with borrow on the registered lags
    assign lag_long    = rd_long_valid_reg  ? rd_long  : '0;
    assign lag_short   = rd_short_valid_reg ? rd_short : '0;
    assign sub_sum     = {1'b0, lag_long} + (swb_pkg::WORD_W+1)'(borrow_reg);
    assign diff        = {1'b0, lag_short} - sub_sum;
    assign borrow_next = (sub_sum > {1'b0, lag_short});

    assign req_fire  = req.valid && req.ready;
    assign calc_fire = calc_en && (!out_valid_reg || rsp.ready);

    // ring write port shared by seeding and next requests
    assign wr_en   = calc_fire || seed_status.wr_en;
    assign wr_addr = seeding ? seed_addr : ptr_reg;
    assign wr_data = seeding ? seed_data : diff[swb_pkg::WORD_W-1:0];

    assign ptr_next = (ptr_reg == PTR_W'(LONG_LAG - 1)) ? '0 : ptr_reg + 1'b1;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            swb_pkg::ST_IDLE:
            begin
                if (req_fire)
                begin
                    state_next = (req.req_type == swb_pkg::REQ_NEXT) ?
                                 swb_pkg::ST_CALC : swb_pkg::ST_SEED;
                end
            end
            swb_pkg::ST_CALC: if (calc_fire) state_next = swb_pkg::ST_IDLE;
            swb_pkg::ST_SEED: if (seed_status.done) state_next = swb_pkg::ST_IDLE;
            default:          state_next = swb_pkg::ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        req.ready  = (state_reg == swb_pkg::ST_IDLE);
        calc_en    = (state_reg == swb_pkg::ST_CALC);
        seeding    = (state_reg == swb_pkg::ST_SEED);
        seed_start = (state_reg == swb_pkg::ST_IDLE) && req.valid &&
                     (req.req_type == swb_pkg::REQ_SEED);
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= swb_pkg::ST_IDLE;
            ptr_reg            <= '0;
            borrow_reg         <= 1'b0;
            slot_valid_reg     <= '0;
            rd_long_valid_reg  <= 1'b0;
            rd_short_valid_reg <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg          <= state_next;
            rd_long_valid_reg  <= slot_valid_reg[ptr_reg];
            rd_short_valid_reg <= slot_valid_reg[q_ptr];
            if (wr_en)
            begin
                slot_valid_reg[wr_addr] <= 1'b1;
            end
            if (calc_fire)
            begin
                ptr_reg       <= ptr_next;
                borrow_reg    <= borrow_next;
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (seed_status.done)
            begin
                ptr_reg    <= '0;
                borrow_reg <= 1'b0;
            end
        end
    end

    // output word
    always_ff @(posedge clk)
    begin
        if (calc_fire)
        begin
            out_word_reg <= diff[swb_pkg::WORD_W-1:0];
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.random_word = out_word_reg;

endmodule

[tb/sv/swb_random_generator_unit_tb.sv]
// swb_random_generator_unit_tb: self-checking bench for the subtract-with-borrow generator
// depends on swb_pkg, swb_if and swb_random_generator_unit; predicts every word in-bench
module swb_random_generator_unit_tb;
    import swb_pkg::*;

    localparam int unsigned RING_LEN  = 43;
    localparam int unsigned SHORT_TAP = 22;

    typedef struct packed {
        logic              drain_first;
        logic              req_type;
        logic [WORD_W-1:0] seed_value;
    } gen_request_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic              drv_valid = 1'b0;
    logic              drv_type = REQ_SEED;
    logic [WORD_W-1:0] drv_seed = '0;
    logic              sink_ready = 1'b0;

    swb_req_if req_ch ();
    swb_rsp_if rsp_ch ();

    assign req_ch.valid      = drv_valid;
    assign req_ch.req_type   = drv_type;
    assign req_ch.seed_value = drv_seed;
    assign rsp_ch.ready      = sink_ready;

    swb_random_generator_unit #(
        .LONG_LAG  (RING_LEN),
        .SHORT_LAG (SHORT_TAP)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // predicted generator state
    logic [WORD_W-1:0] ring_words [RING_LEN];
    logic              ring_borrow;
    int unsigned       ring_slot;

    gen_request_t      pending_reqs [$];
    logic [WORD_W-1:0] expected_words [$];

    int unsigned offered_count  = 0;
    int unsigned accepted_count = 0;
    int unsigned words_received = 0;
    int unsigned mismatch_count = 0;

    int unsigned  burst_left = 8;
    int unsigned  gap_left   = 0;
    gen_request_t cur_req;

    int unsigned sink_cycle = 0;
    int unsigned stall_pct  = 0;
    int unsigned hold_left  = 0;
    logic        hold_done  = 1'b0;

    logic [WORD_W-1:0] want_word;

    // fill the ring from a seed: lag-3 product sequence mixed with a mod-169 sequence
    function automatic void reseed_ring(input logic [WORD_W-1:0] seed);
        logic [WORD_W-1:0] wrapped;
        logic [WORD_W-1:0] cong;
        logic [WORD_W-1:0] acc;
        int unsigned       hist [3];
        int unsigned       prod;
        int unsigned       oldest;
        wrapped = LCG_MUL * seed + LCG_ADD;
        hist[0] = wrapped % RING_LEN;
        wrapped = LCG_MUL * hist[0] + LCG_ADD;
        hist[1] = wrapped % RING_LEN;
        wrapped = LCG_MUL * hist[1] + LCG_ADD;
        hist[2] = wrapped % RING_LEN;
        cong    = seed;
        oldest  = 0;
        for (int w = 0; w < RING_LEN; w++)
        begin
            acc = '0;
            for (int b = 0; b < WORD_W; b++)
            begin
                prod    = ((hist[0] * hist[1]) % PROD_MOD) * hist[2] % PROD_MOD;
                wrapped = CONG_MUL * cong + CONG_ADD;
                cong    = wrapped % CONG_MOD;
                acc[WORD_W-1-b] = ((prod * cong) % BIT_MOD) >= BIT_THRESH;
                hist[oldest] = prod;
                oldest = (oldest + 1) % 3;
            end
            ring_words[w] = acc;
        end
        ring_slot   = 0;
        ring_borrow = 1'b0;
    endfunction

    // one subtract-with-borrow step, returns the stored word
    function automatic logic [WORD_W-1:0] next_word();
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        logic [WORD_W:0]   sub;
        int unsigned       q;
        q   = (ring_slot + RING_LEN - (SHORT_TAP % RING_LEN)) % RING_LEN;
        a   = ring_words[q];
        b   = ring_words[ring_slot];
        sub = {1'b0, b} + ring_borrow;
        ring_borrow = (sub > {1'b0, a});
        ring_words[ring_slot] = a - sub[WORD_W-1:0];
        next_word = ring_words[ring_slot];
        ring_slot = (ring_slot + 1) % RING_LEN;
    endfunction

    function automatic void queue_request(input logic kind, input logic [WORD_W-1:0] seed,
                                          input logic drain);
        gen_request_t r;
        r.drain_first = drain;
        r.req_type    = kind;
        r.seed_value  = seed;
        pending_reqs.push_back(r);
    endfunction

    // clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // request driver: bursts with random gaps, holds an offer until it is taken
    always @(negedge clk)
    begin
        if (rst_n && offered_count == accepted_count)
        begin
            if (gap_left != 0)
            begin
                gap_left--;
                drv_valid <= 1'b0;
            end
            else if (pending_reqs.size() == 0 ||
                     (pending_reqs[0].drain_first && expected_words.size() != 0))
            begin
                drv_valid <= 1'b0;
            end
            else
            begin
                cur_req = pending_reqs.pop_front();
                drv_valid <= 1'b1;
                drv_type  <= cur_req.req_type;
                drv_seed  <= cur_req.seed_value;
                offered_count++;
                burst_left--;
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
        end
    end

    // response sink: stall rate redrawn periodically, one long hold-off
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            sink_cycle++;
            if (sink_cycle % 64 == 0)
            begin
                case ($urandom_range(0, 4))
                    0, 1:    stall_pct = 0;
                    2:       stall_pct = 25;
                    3:       stall_pct = 60;
                    default: stall_pct = 90;
                endcase
            end
            if (!hold_done && words_received >= 300)
            begin
                hold_left = 250;
                hold_done = 1'b1;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                sink_ready <= 1'b0;
            end
            else
            begin
                sink_ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // accepted request: update the predicted state
    always @(posedge clk)
    begin
        if (rst_n && req_ch.valid && req_ch.ready)
        begin
            accepted_count++;
            if (req_ch.req_type == REQ_NEXT)
                expected_words.push_back(next_word());
            else
                reseed_ring(req_ch.seed_value);
        end
    end

    // accepted word: compare with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            words_received++;
            if (expected_words.size() == 0)
            begin
                $error("random_word: no word expected, actual %h", rsp_ch.random_word);
                mismatch_count++;
            end
            else
            begin
                want_word = expected_words.pop_front();
                if (rsp_ch.random_word !== want_word)
                begin
                    $error("random_word: expected %h, actual %h", want_word,
                           rsp_ch.random_word);
                    mismatch_count++;
                end
            end
        end
    end

    // run limit
    initial
    begin
        #20000000;
        $display("swb_random_generator_unit_tb: errors");
        $finish;
    end

    // stimulus, reset and end of run
    initial
    begin
        int remaining;
        int run_len;
        logic drain_done;

        for (int i = 0; i < RING_LEN; i++)
            ring_words[i] = '0;
        ring_borrow = 1'b0;
        ring_slot   = 0;

        // next on the cleared ring gives zeros
        repeat (3) queue_request(REQ_NEXT, $urandom, 1'b0);
        // seed extremes and back-to-back seeds
        queue_request(REQ_SEED, '0, 1'b0);
        repeat (5) queue_request(REQ_NEXT, $urandom, 1'b0);
        queue_request(REQ_SEED, '1, 1'b0);
        queue_request(REQ_SEED, 32'h0000_0001, 1'b0);
        repeat (5) queue_request(REQ_NEXT, $urandom, 1'b0);
        queue_request(REQ_SEED, $urandom, 1'b0);
        repeat (4) queue_request(REQ_NEXT, $urandom, 1'b0);

        // random segments: one reseed then a long run of next requests
        remaining  = 1330;
        drain_done = 1'b0;
        while (remaining > 10)
        begin
            run_len = $urandom_range(200, 400);
            queue_request(REQ_SEED, $urandom, 1'b0);
            remaining--;
            for (int i = 0; i < run_len && remaining > 0; i++)
            begin
                queue_request(REQ_NEXT, $urandom, !drain_done && remaining <= 700);
                if (remaining <= 700)
                    drain_done = 1'b1;
                remaining--;
            end
        end

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_reqs.size() != 0 || offered_count != accepted_count)
            @(posedge clk);
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        if (mismatch_count == 0 && expected_words.size() == 0)
            $display("swb_random_generator_unit_tb: clean");
        else
            $display("swb_random_generator_unit_tb: errors");
        $finish;
    end

endmodule
